FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/bmre_pkg.sv
// Shared types and constants of the border marker range extractor.
`default_nettype none
package bmre_pkg;
	localparam int MAX_LINE_LENGTH = 4096;
	localparam int POS_W   = $clog2(MAX_LINE_LENGTH);
	localparam int COORD_W = 12;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam logic [31:0] COLOR_WHITE = 32'hffff_ffff;
	localparam logic [31:0] COLOR_BLACK = 32'hff00_0000;
	localparam logic [31:0] COLOR_RED   = 32'hffff_0000;

	localparam logic [POS_W-1:0]   POS_MAX = POS_W'(MAX_LINE_LENGTH - 1);
	localparam logic [COORD_W-1:0] ERR_POS = COORD_W'(MAX_LINE_LENGTH - 2);

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [POS_W-1:0]   pos_t;

	typedef enum logic [1:0] {
		KIND_BLACK = 2'd0,
		KIND_RED   = 2'd1,
		KIND_ERROR = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	// One classified pixel: an optional closed run, then an optional status.
	typedef struct packed {
		logic   run_vld;
		kind_t  run_kind;
		coord_t run_start;
		coord_t run_end;
		logic   stat_vld;
		kind_t  stat_kind;
		coord_t stat_pos;
	} entry_t;
endpackage
`default_nettype wire

FILE: rtl/bmre_front.sv
// Front end: classifies pixels, tracks the line state and builds queue entries.
`default_nettype none
module bmre_front import bmre_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_data,
	input  wire logic        accept,
	input  wire logic [31:0] pixel,
	input  wire logic        line_end,
	output entry_t           entry,
	output logic             entry_vld
);
	logic   neutral_mode_q;
	pos_t   pos_q;
	coord_t start_q;
	logic   err_q;
	logic   prev_mark_q;
	logic   prev_red_q;

	logic   is_black, is_red, is_marker, pix_valid, chg, sat;
	pos_t   inner;

	always_comb begin
		is_black  = (pixel == COLOR_BLACK);
		is_red    = (pixel == COLOR_RED);
		is_marker = is_black | is_red;
		pix_valid = is_marker | (neutral_mode_q ? (pixel == COLOR_WHITE)
		                                        : (pixel[31:24] == 8'h00));
		chg       = !((prev_mark_q == is_marker) && (!is_marker || (prev_red_q == is_red)));
		sat       = (pos_q == POS_MAX);
		inner     = pos_q - POS_W'(1);
	end

	always_comb begin
		entry     = '0;
		entry_vld = 1'b0;
		if (line_end) begin
			entry_vld      = 1'b1;
			entry.stat_vld = 1'b1;
			entry.stat_kind = KIND_DONE;
			if ((pos_q != '0) && !err_q && prev_mark_q) begin
				entry.run_vld   = 1'b1;
				entry.run_kind  = prev_red_q ? KIND_RED : KIND_BLACK;
				entry.run_start = start_q;
				entry.run_end   = COORD_W'(inner);
			end
		end else if ((pos_q != '0) && !err_q) begin
			if (sat || !pix_valid) begin
				entry_vld       = 1'b1;
				entry.stat_vld  = 1'b1;
				entry.stat_kind = KIND_ERROR;
				entry.stat_pos  = sat ? ERR_POS : COORD_W'(inner);
			end else if (chg && prev_mark_q) begin
				entry_vld       = 1'b1;
				entry.run_vld   = 1'b1;
				entry.run_kind  = prev_red_q ? KIND_RED : KIND_BLACK;
				entry.run_start = start_q;
				entry.run_end   = COORD_W'(inner);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neutral_mode_q <= 1'b0;
			pos_q          <= '0;
			start_q        <= '0;
			err_q          <= 1'b0;
			prev_mark_q    <= 1'b0;
			prev_red_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				neutral_mode_q <= cfg_data;
			end
			if (accept) begin
				if (line_end) begin
					pos_q       <= '0;
					start_q     <= '0;
					err_q       <= 1'b0;
					prev_mark_q <= 1'b0;
					prev_red_q  <= 1'b0;
				end else if (pos_q == '0) begin
					pos_q <= POS_W'(1);
				end else begin
					if (!sat) begin
						pos_q <= pos_q + POS_W'(1);
					end
					if (!err_q) begin
						if (sat || !pix_valid) begin
							err_q <= 1'b1;
						end else if (chg) begin
							prev_mark_q <= is_marker;
							prev_red_q  <= is_red;
							if (is_marker) begin
								start_q <= COORD_W'(inner);
							end
						end
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/bmre_queue.sv
// Small entry queue between the front end and the result stage.
`default_nettype none
module bmre_queue import bmre_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire entry_t wr_data,
	input  wire logic   rd_en,
	output entry_t      rd_data,
	output logic        rd_vld,
	output logic        full
);
	entry_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]     count_q;

	assign rd_data = mem_q[rd_ptr_q];
	assign rd_vld  = (count_q != '0);
	assign full    = (count_q == (Q_PTR_W+1)'(Q_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (Q_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (Q_PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/bmre_back.sv
// Result stage: expands queue entries into single results in an output register.
`default_nettype none
module bmre_back import bmre_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire entry_t head,
	input  wire logic   head_vld,
	output logic        deq,
	input  wire logic   pop,
	output logic        empty,
	output kind_t       kind,
	output coord_t      range_start,
	output coord_t      range_end,
	output logic        last
);
	logic out_vld_q;
	logic phase_q;
	logic load, take_run;

	assign empty    = !out_vld_q;
	assign load     = head_vld && (!out_vld_q || pop);
	assign take_run = head.run_vld && !phase_q;
	assign deq      = load && !(take_run && head.stat_vld);

	always_ff @(posedge clk) begin
		if (load) begin
			if (take_run) begin
				kind        <= head.run_kind;
				range_start <= head.run_start;
				range_end   <= head.run_end;
				last        <= 1'b0;
			end else begin
				kind        <= head.stat_kind;
				range_start <= head.stat_pos;
				range_end   <= '0;
				last        <= (head.stat_kind == KIND_DONE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			phase_q   <= 1'b0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			if (load) begin
				phase_q <= take_run && head.stat_vld;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/border_marker_range_extractor.sv
// Top level of the border marker range extractor.
// Usage:
//   Input queue: drive pixel and line_end, raise push; a transaction takes place
//   at a clock edge with push high and full low. Feed one border line per
//   sequence, line_end set on its final corner pixel.
//   Result queue: while empty is low, kind/range_start/range_end/last show the
//   oldest result; pop high at a clock edge takes it.
//   Config: cfg_valid with cfg_data writes neutral_mode; cfg_ready is always high.
// Timing:
//   One pixel per cycle sustained while full is low. The front end classifies a
//   pixel in the cycle it is taken; its entry is written into the 4-deep queue at
//   that edge and then passes from the queue head into the output register,
//   where it waits on the result ports until it is popped.
//   A line end may yield two results, drained one per cycle while pop stays high.
// Stall and reset:
//   A stalled receiver holds the output register; entries pile up in the queue
//   and full rises when it holds 4 entries. Reset clears the line state, the
//   queue and the valid flag of the output register; neutral_mode returns to 0.
`default_nettype none
module border_marker_range_extractor import bmre_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] pixel,
	input  wire logic        line_end,
	input  wire logic        pop,
	output logic             empty,
	output logic [1:0]       kind,
	output logic [11:0]      range_start,
	output logic [11:0]      range_end,
	output logic             last
);
	entry_t entry, head;
	logic   entry_vld, accept, head_vld, deq;
	kind_t  kind_w;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;
	assign kind      = kind_w;

	bmre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.pixel     (pixel),
		.line_end  (line_end),
		.entry     (entry),
		.entry_vld (entry_vld)
	);

	bmre_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && entry_vld),
		.wr_data (entry),
		.rd_en   (deq),
		.rd_data (head),
		.rd_vld  (head_vld),
		.full    (full)
	);

	bmre_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_vld    (head_vld),
		.deq         (deq),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind_w),
		.range_start (range_start),
		.range_end   (range_end),
		.last        (last)
	);
endmodule
`default_nettype wire

FILE: rtl/bmre_checker.sv
// Port-level checker for the border marker range extractor, with its bind.
`default_nettype none
`include "assert_macros.svh"
module bmre_checker import bmre_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pop,
	input wire logic        empty,
	input wire logic [1:0]  kind,
	input wire logic [11:0] range_start,
	input wire logic [11:0] range_end,
	input wire logic        last
);
	`AST_IMPLY(a_last_on_done, clk, arst_n, !empty, last == (kind == KIND_DONE))
	`AST_IMPLY(a_status_end_zero, clk, arst_n, !empty && (kind == KIND_ERROR || kind == KIND_DONE), range_end == 12'd0)
	`AST_IMPLY(a_done_start_zero, clk, arst_n, !empty && kind == KIND_DONE, range_start == 12'd0)
	`AST_NEXT(a_stall_holds, clk, arst_n, !empty && !pop, !empty && $stable(kind) && $stable(range_start) && $stable(range_end))
endmodule

bind border_marker_range_extractor bmre_checker u_bmre_checker (.*);
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for border_marker_range_extractor: directed table and random lines.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bmre_pkg::*;

	localparam int CYCLE_LIMIT  = 6_000_000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_ITEMS  = 360;

	typedef struct packed {
		kind_t  kind;
		coord_t start_at;
		coord_t end_at;
		logic   last_flag;
	} run_result_t;

	typedef struct packed {
		logic        cfg;
		logic [31:0] px;
		logic        eol;
		logic        typed;
		logic [1:0]  n;
		run_result_t e0;
		run_result_t e1;
	} stim_row_t;

	localparam run_result_t NO_R   = '0;
	localparam run_result_t DONE_R = '{KIND_DONE, 12'd0, 12'd0, 1'b1};

	localparam stim_row_t DIRECTED [27] = '{
		'{1'b0, COLOR_BLACK,   1'b0, 1'b1, 2'd0, NO_R, NO_R},
		'{1'b0, 32'h0000_0000, 1'b1, 1'b1, 2'd1, DONE_R, NO_R},
		'{1'b0, 32'hffff_ffff, 1'b1, 1'b1, 2'd1, DONE_R, NO_R},
		'{1'b0, 32'h8080_8080, 1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, COLOR_BLACK,   1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, COLOR_BLACK,   1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, COLOR_RED,     1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, 32'h00ab_cdef, 1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, 32'h1234_5678, 1'b0, 1'b1, 2'd1,
			'{KIND_ERROR, 12'd4, 12'd0, 1'b0}, NO_R},
		'{1'b0, COLOR_BLACK,   1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, 32'h0000_0000, 1'b1, 1'b1, 2'd1, DONE_R, NO_R},
		'{1'b0, 32'hffff_ffff, 1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, COLOR_RED,     1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, 32'h00ff_ffff, 1'b1, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, 32'h0000_0000, 1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, 32'h0000_0000, 1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, 32'hffff_ffff, 1'b0, 1'b1, 2'd1,
			'{KIND_ERROR, 12'd1, 12'd0, 1'b0}, NO_R},
		'{1'b0, 32'h0000_0000, 1'b1, 1'b1, 2'd1, DONE_R, NO_R},
		'{1'b1, 32'h0000_0001, 1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, 32'hffff_ffff, 1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, 32'h0000_0000, 1'b0, 1'b1, 2'd1,
			'{KIND_ERROR, 12'd0, 12'd0, 1'b0}, NO_R},
		'{1'b0, COLOR_BLACK,   1'b1, 1'b1, 2'd1, DONE_R, NO_R},
		'{1'b0, 32'h0000_0000, 1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, COLOR_WHITE,   1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, COLOR_BLACK,   1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, COLOR_WHITE,   1'b0, 1'b0, 2'd0, NO_R, NO_R},
		'{1'b0, COLOR_RED,     1'b1, 1'b0, 2'd0, NO_R, NO_R}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_data = 1'b0;
	logic        push = 1'b0;
	logic [31:0] pixel = '0;
	logic        line_end = 1'b0;
	logic        pop = 1'b0;
	logic        cfg_ready;
	logic        full;
	logic        empty;
	logic [1:0]  kind;
	logic [11:0] range_start;
	logic [11:0] range_end;
	logic        last;

	// predictor state
	logic [31:0] prev_color = COLOR_WHITE;
	logic [12:0] line_pos = '0;
	coord_t      run_open = '0;
	bit          line_err = 1'b0;
	bit          neutral_white = 1'b0;

	run_result_t pending_ranges[$];
	bit          hold_request = 1'b0;
	int          mismatches = 0;
	int          items_sent = 0;
	int          lines_sent = 0;
	int          results_checked = 0;
	int          error_reports = 0;
	int          stall_cycles = 0;
	int          cycle_count = 0;

	border_marker_range_extractor u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.pixel       (pixel),
		.line_end    (line_end),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.range_start (range_start),
		.range_end   (range_end),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (push && full)
			stall_cycles++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic bit is_marker(input logic [31:0] c);
		return c == COLOR_BLACK || c == COLOR_RED;
	endfunction

	function automatic kind_t marker_kind(input logic [31:0] c);
		return c == COLOR_BLACK ? KIND_BLACK : KIND_RED;
	endfunction

	// Advances the line state by one pixel; returns the number of results it produces.
	function automatic int extract_ranges(input logic [31:0] color, input logic eol,
		output run_result_t r0, output run_result_t r1);
		run_result_t res [2];
		logic [12:0] p;
		bit          ok;
		int          n;
		res[0] = NO_R;
		res[1] = NO_R;
		n = 0;
		p = line_pos;
		ok = is_marker(color) ||
			(neutral_white ? color == COLOR_WHITE : color[31:24] == 8'h00);
		if (eol) begin
			if (p != 0 && !line_err && is_marker(prev_color)) begin
				res[0] = '{marker_kind(prev_color), run_open, coord_t'(p - 13'd1), 1'b0};
				n = 1;
			end
			res[n] = DONE_R;
			n++;
			prev_color = COLOR_WHITE;
			line_pos = '0;
			run_open = '0;
			line_err = 1'b0;
		end else if (p == 0) begin
			line_pos = 13'd1;
		end else begin
			if (p < MAX_LINE_LENGTH - 1)
				line_pos = p + 13'd1;
			if (!line_err) begin
				if (p >= MAX_LINE_LENGTH - 1 || !ok) begin
					line_err = 1'b1;
					res[0] = '{KIND_ERROR,
						p >= MAX_LINE_LENGTH - 1 ? ERR_POS : coord_t'(p - 13'd1),
						12'd0, 1'b0};
					n = 1;
				end else if (color != prev_color) begin
					if (is_marker(prev_color)) begin
						res[0] = '{marker_kind(prev_color), run_open,
							coord_t'(p - 13'd1), 1'b0};
						n = 1;
					end
					if (is_marker(color))
						run_open = coord_t'(p - 13'd1);
					prev_color = color;
				end
			end
		end
		r0 = res[0];
		r1 = res[1];
		return n;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_pixel(input logic [31:0] prev, input bit clean);
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return prev;
		r = $urandom_range(0, 99);
		if (r < 25)
			return COLOR_BLACK;
		if (r < 50)
			return COLOR_RED;
		if (clean || r < 85)
			return neutral_white ? COLOR_WHITE : {8'h00, 24'($urandom)};
		if (r < 93)
			return neutral_white ? {8'h00, 24'($urandom)} : COLOR_WHITE;
		return $urandom;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch on %s at result %0d: got %0h, expected %0h",
			what, results_checked, got, want);
		mismatches++;
	endtask

	task automatic take_result();
		run_result_t want;
		if (pending_ranges.size() == 0) begin
			note_mismatch("unexpected transaction", {kind, range_start, range_end, last}, 0);
			return;
		end
		want = pending_ranges.pop_front();
		if (kind !== want.kind)
			note_mismatch("kind", kind, want.kind);
		if (range_start !== want.start_at)
			note_mismatch("range_start", range_start, want.start_at);
		if (range_end !== want.end_at)
			note_mismatch("range_end", range_end, want.end_at);
		if (last !== want.last_flag)
			note_mismatch("last", last, want.last_flag);
		if (want.kind == KIND_ERROR)
			error_reports++;
		results_checked++;
	endtask

	task automatic tx_pause(input int n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_pixel(input logic [31:0] px, input logic eol,
		input bit typed = 1'b0, input int tn = 0,
		input run_result_t t0 = '0, input run_result_t t1 = '0);
		run_result_t r0, r1;
		int          n;
		push <= 1'b1;
		pixel <= px;
		line_end <= eol;
		@(posedge clk);
		while (full)
			@(posedge clk);
		n = extract_ranges(px, eol, r0, r1);
		if (typed) begin
			n = tn;
			r0 = t0;
			r1 = t1;
		end
		if (n > 0)
			pending_ranges.insert(pending_ranges.size(), r0);
		if (n > 1)
			pending_ranges.insert(pending_ranges.size(), r1);
		items_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_ranges.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		neutral_white = v;
	endtask

	task automatic feed_line(input int inner, input bit calm, input bit noisy,
		input bit black_tail);
		logic [31:0] px;
		px = COLOR_RED;
		send_pixel($urandom, 1'b0);
		tx_pause(calm ? 0 : gap_len());
		for (int k = 0; k < inner; k++) begin
			px = (black_tail && k >= inner - 3) ? COLOR_BLACK : pick_pixel(px, !noisy);
			send_pixel(px, 1'b0);
			tx_pause(calm ? 0 : gap_len());
		end
		send_pixel($urandom, 1'b1);
		tx_pause(calm ? 0 : gap_len());
		lines_sent++;
	endtask

	// result side
	initial begin
		int hold_left;
		int idle_left;
		int calm_left;
		hold_left = 0;
		idle_left = 0;
		calm_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				take_result();
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 120;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 9) == 0)
					calm_left = $urandom_range(20, 200);
				else
					idle_left = gap_len();
			end
		end
	end

	// pixel side
	initial begin
		int r;
		int inner;
		int phase_start;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (DIRECTED[i].cfg) begin
				write_mode(DIRECTED[i].px[0]);
			end else begin
				send_pixel(DIRECTED[i].px, DIRECTED[i].eol, DIRECTED[i].typed,
					DIRECTED[i].n, DIRECTED[i].e0, DIRECTED[i].e1);
				tx_pause(gap_len());
			end
		end

		// receiver holds off while alternating markers fill the queue
		drain();
		hold_request = 1'b1;
		send_pixel($urandom, 1'b0);
		for (int k = 0; k < 40; k++)
			send_pixel(k[0] ? COLOR_RED : COLOR_BLACK, 1'b0);
		send_pixel($urandom, 1'b1);
		lines_sent++;

		for (int ph = 0; ph < 4; ph++) begin
			write_mode(ph[0]);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					inner = $urandom_range(0, 1);
				else if (r < 90)
					inner = $urandom_range(2, 30);
				else
					inner = $urandom_range(31, 150);
				feed_line(inner, $urandom_range(0, 4) == 0, $urandom_range(0, 99) < 15,
					$urandom_range(0, 9) == 0);
				if ($urandom_range(0, 49) == 0)
					drain();
			end
		end

		drain();
		repeat (16) @(posedge clk);
		$display("sent %0d pixels in %0d lines under both neutral modes", items_sent, lines_sent);
		$display("checked %0d results (%0d error reports), input stalled %0d cycles",
			results_checked, error_reports, stall_cycles);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

FILE: border_marker_range_extractor.f
+incdir+rtl
rtl/bmre_pkg.sv
rtl/bmre_front.sv
rtl/bmre_queue.sv
rtl/bmre_back.sv
rtl/border_marker_range_extractor.sv
rtl/bmre_checker.sv
tb/tb.sv
